[hdl/swq_pkg.sv]
`timescale 1ns / 1ps

package swq_pkg;

   // defaults for the top-level parameters
   localparam int QUEUE_DEPTH_DEF  = 16;
   localparam int LEVELS_DEF       = 3;
   localparam int HANDLE_WIDTH_DEF = 16;

   // fixed field widths
   localparam int OP_W     = 2;
   localparam int PRIO_W   = 2;
   localparam int STATUS_W = 3;
   localparam int OLEVEL_W = 2;
   localparam int TOTAL_W  = 6;
   localparam int TOTAL_MAX = (1 << TOTAL_W) - 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
   localparam logic [OP_W-1:0] OP_BLOCK   = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_PRIO = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTHING  = 3'd4;

   // controller to datapath command
   typedef struct packed {
      logic exec;   // execute the operation on the request payload this cycle
   } swq_cmd_type;

endpackage

[hdl/swq_if.sv]
`timescale 1ns / 1ps

interface swq_req_if #(
   parameter int HANDLE_WIDTH = swq_pkg::HANDLE_WIDTH_DEF
);
   logic                        valid;
   logic                        ready;
   logic [swq_pkg::OP_W-1:0]    operation;
   logic [swq_pkg::PRIO_W-1:0]  priority_req;
   logic [HANDLE_WIDTH-1:0]     item_handle;

   modport source (output valid, operation, priority_req, item_handle, input ready);
   modport sink (input valid, operation, priority_req, item_handle, output ready);
endinterface

interface swq_rsp_if #(
   parameter int HANDLE_WIDTH = swq_pkg::HANDLE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic [swq_pkg::STATUS_W-1:0]  status;
   logic [HANDLE_WIDTH-1:0]       out_handle;
   logic [swq_pkg::OLEVEL_W-1:0]  out_level;
   logic [swq_pkg::TOTAL_W-1:0]   total_length;
   logic                          all_empty;
   logic                          empty_event;
   logic                          wake_pulse;

   modport source (output valid, status, out_handle, out_level, total_length, all_empty,
                   empty_event, wake_pulse, input ready);
   modport sink (input valid, status, out_handle, out_level, total_length, all_empty,
                 empty_event, wake_pulse, output ready);
endinterface

[hdl/swq_ctrl.sv]
`timescale 1ns / 1ps

module swq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output swq_pkg::swq_cmd_type cmd
);

   typedef enum logic [0:0] {
      S_IDLE,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd.exec  = req_valid && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff     <= S_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

[hdl/swq_datapath.sv]
`timescale 1ns / 1ps

module swq_datapath #(
   parameter int QUEUE_DEPTH  = swq_pkg::QUEUE_DEPTH_DEF,
   parameter int LEVELS       = swq_pkg::LEVELS_DEF,
   parameter int HANDLE_WIDTH = swq_pkg::HANDLE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swq_pkg::swq_cmd_type          cmd,
   input  logic [swq_pkg::OP_W-1:0]      operation,
   input  logic [swq_pkg::PRIO_W-1:0]    priority_req,
   input  logic [HANDLE_WIDTH-1:0]       item_handle,
   output logic [swq_pkg::STATUS_W-1:0]  status,
   output logic [HANDLE_WIDTH-1:0]       out_handle,
   output logic [swq_pkg::OLEVEL_W-1:0]  out_level,
   output logic [swq_pkg::TOTAL_W-1:0]   total_length,
   output logic                          all_empty,
   output logic                          empty_event,
   output logic                          wake_pulse
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int ENTRIES = LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int TOT_W  = $clog2(ENTRIES + 1);

   // per-level queue state
   logic [PTR_W-1:0] rd_ptr_ff [LEVELS];
   logic [PTR_W-1:0] wr_ptr_ff [LEVELS];
   logic [CNT_W-1:0] cnt_ff    [LEVELS];
   logic             blocked_ff;
   logic [TOT_W-1:0] tot_ff;

   // handle storage, one QUEUE_DEPTH slice per level
   logic [HANDLE_WIDTH-1:0] mem [ENTRIES];
   logic [HANDLE_WIDTH-1:0] rd_data_ff;

   // response registers
   logic [swq_pkg::STATUS_W-1:0] status_ff;
   logic [swq_pkg::OLEVEL_W-1:0] level_ff;
   logic [swq_pkg::TOTAL_W-1:0]  total_ff;
   logic                         empty_ff;
   logic                         event_ff;
   logic                         wake_ff;
   logic                         pop_ff;

   logic [LVL_W-1:0]            enq_lvl;
   logic [LVL_W-1:0]            pop_lvl;
   logic                        found;
   logic                        bad_prio;
   logic                        enq_full;
   logic                        enq_ok;
   logic                        pop_ok;
   logic [PTR_W-1:0]            wr_ptr_in;
   logic [PTR_W-1:0]            rd_ptr_in;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           rd_addr;
   logic [TOT_W-1:0]            tot_in;
   logic [swq_pkg::STATUS_W-1:0] status_in;
   logic                        event_in;

   assign enq_lvl  = LVL_W'(priority_req);
   assign bad_prio = (int'(priority_req) >= LEVELS);

   // highest non-empty level wins: later (higher) levels override
   always_comb begin
      found   = 1'b0;
      pop_lvl = '0;
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (cnt_ff[lv] != '0) begin
            found   = 1'b1;
            pop_lvl = LVL_W'(lv);
         end
      end
   end

   always_comb begin
      enq_full  = 1'b0;
      wr_ptr_in = '0;
      if (!bad_prio) begin
         enq_full  = (cnt_ff[enq_lvl] == CNT_W'(QUEUE_DEPTH));
         wr_ptr_in = (wr_ptr_ff[enq_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff[enq_lvl] + PTR_W'(1);
      end
   end

   assign rd_ptr_in = (rd_ptr_ff[pop_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                    : rd_ptr_ff[pop_lvl] + PTR_W'(1);

   assign wr_addr = ADDR_W'(enq_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_ptr_ff[enq_lvl]);
   assign rd_addr = ADDR_W'(pop_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rd_ptr_ff[pop_lvl]);

   assign enq_ok = (operation == swq_pkg::OP_ENQUEUE) && !blocked_ff && !bad_prio && !enq_full;
   assign pop_ok = (operation == swq_pkg::OP_DEQUEUE) && found;

   always_comb begin
      status_in = swq_pkg::ST_OK;
      event_in  = 1'b0;
      tot_in    = tot_ff;
      case (operation)
         swq_pkg::OP_ENQUEUE: begin
            if (blocked_ff) begin
               status_in = swq_pkg::ST_BLOCKED;
            end else if (bad_prio) begin
               status_in = swq_pkg::ST_BAD_PRIO;
            end else if (enq_full) begin
               status_in = swq_pkg::ST_FULL;
            end else begin
               tot_in = tot_ff + TOT_W'(1);
            end
         end
         swq_pkg::OP_DEQUEUE: begin
            if (found) begin
               tot_in = tot_ff - TOT_W'(1);
            end else begin
               status_in = swq_pkg::ST_NOTHING;
               event_in  = blocked_ff;
            end
         end
         swq_pkg::OP_CLEAR: begin
            tot_in = '0;
         end
         default: begin
            event_in = (tot_ff == '0);
         end
      endcase
   end

   // queue control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            rd_ptr_ff[lv] <= '0;
            wr_ptr_ff[lv] <= '0;
            cnt_ff[lv]    <= '0;
         end
         blocked_ff <= 1'b0;
         tot_ff     <= '0;
      end else if (cmd.exec) begin
         tot_ff <= tot_in;
         case (operation)
            swq_pkg::OP_ENQUEUE: begin
               if (enq_ok) begin
                  wr_ptr_ff[enq_lvl] <= wr_ptr_in;
                  cnt_ff[enq_lvl]    <= cnt_ff[enq_lvl] + CNT_W'(1);
               end
            end
            swq_pkg::OP_DEQUEUE: begin
               if (found) begin
                  rd_ptr_ff[pop_lvl] <= rd_ptr_in;
                  cnt_ff[pop_lvl]    <= cnt_ff[pop_lvl] - CNT_W'(1);
               end
            end
            swq_pkg::OP_CLEAR: begin
               for (int lv = 0; lv < LEVELS; lv++) begin
                  rd_ptr_ff[lv] <= '0;
                  wr_ptr_ff[lv] <= '0;
                  cnt_ff[lv]    <= '0;
               end
            end
            default: begin
               blocked_ff <= 1'b1;
            end
         endcase
      end
   end

   // storage: at most one write or one registered read per transfer
   always_ff @(posedge clock) begin
      if (cmd.exec && enq_ok) begin
         mem[wr_addr] <= item_handle;
      end
      if (cmd.exec && pop_ok) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         level_ff  <= pop_ok ? swq_pkg::OLEVEL_W'(pop_lvl) : '0;
         total_ff  <= (int'(tot_in) > swq_pkg::TOTAL_MAX) ? swq_pkg::TOTAL_W'(swq_pkg::TOTAL_MAX)
                                                         : swq_pkg::TOTAL_W'(tot_in);
         empty_ff  <= (tot_in == '0);
         event_ff  <= event_in;
         wake_ff   <= enq_ok;
         pop_ff    <= pop_ok;
      end
   end

   assign status       = status_ff;
   assign out_handle   = pop_ff ? rd_data_ff : '0;
   assign out_level    = level_ff;
   assign total_length = total_ff;
   assign all_empty    = empty_ff;
   assign empty_event  = event_ff;
   assign wake_pulse   = wake_ff;

endmodule

[hdl/strict_priority_work_queue.sv]
`timescale 1ns / 1ps
// Latency: the result is valid on the cycle after the request transfer.
// The controller holds off the next request until the result transfer completes.
// Reset (synchronous, active high): all queues empty, not blocked, no result pending.
//   Handle storage is not cleared; only written entries are ever read.

module strict_priority_work_queue #(
   parameter int QUEUE_DEPTH  = swq_pkg::QUEUE_DEPTH_DEF,
   parameter int LEVELS       = swq_pkg::LEVELS_DEF,
   parameter int HANDLE_WIDTH = swq_pkg::HANDLE_WIDTH_DEF
) (
   input logic  clock,
   input logic  reset,
   swq_req_if.sink   req_chan,
   swq_rsp_if.source rsp_chan
);

   swq_pkg::swq_cmd_type cmd;

   swq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   swq_datapath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .LEVELS       (LEVELS),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .operation    (req_chan.operation),
      .priority_req (req_chan.priority_req),
      .item_handle  (req_chan.item_handle),
      .status       (rsp_chan.status),
      .out_handle   (rsp_chan.out_handle),
      .out_level    (rsp_chan.out_level),
      .total_length (rsp_chan.total_length),
      .all_empty    (rsp_chan.all_empty),
      .empty_event  (rsp_chan.empty_event),
      .wake_pulse   (rsp_chan.wake_pulse)
   );

endmodule

[bench/strict_priority_work_queue_tb.sv]
`timescale 1ns / 1ps

module strict_priority_work_queue_tb;

   localparam int DEPTH       = swq_pkg::QUEUE_DEPTH_DEF;
   localparam int NLEV        = swq_pkg::LEVELS_DEF;
   localparam int HW          = swq_pkg::HANDLE_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [swq_pkg::OP_W-1:0]   op;
      logic [swq_pkg::PRIO_W-1:0] prio;
      logic [HW-1:0]              handle;
   } work_req_type;

   typedef struct packed {
      logic [swq_pkg::STATUS_W-1:0] status;
      logic [HW-1:0]                handle;
      logic [swq_pkg::OLEVEL_W-1:0] level;
      logic [swq_pkg::TOTAL_W-1:0]  total;
      logic                         all_empty;
      logic                         empty_ev;
      logic                         wake;
   } work_rsp_type;

   logic clock;
   logic reset;

   swq_req_if #(.HANDLE_WIDTH(HW)) req_chan ();
   swq_rsp_if #(.HANDLE_WIDTH(HW)) rsp_chan ();

   strict_priority_work_queue #(
      .QUEUE_DEPTH (DEPTH),
      .LEVELS      (NLEV),
      .HANDLE_WIDTH(HW)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   work_req_type ops_to_send [$];
   work_rsp_type queue_outcomes [$];

   // mirror of the queue contents
   logic [HW-1:0] mirror_slot [NLEV*DEPTH];
   int            mirror_rd [NLEV];
   int            mirror_wr [NLEV];
   int            mirror_count [NLEV];
   bit            mirror_blocked;

   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int cycle_count;
   int hold_left;
   bit hold_toggle;
   bit hold_seen;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int queued_total();
      int sum;
      sum = 0;
      for (int lv = 0; lv < NLEV; lv++) sum += mirror_count[lv];
      return sum;
   endfunction

   // outcome of one accepted operation on the mirrored queues
   function automatic void apply_work_op(input work_req_type r);
      work_rsp_type o;
      int           lvl;
      int           total;
      bit           found;
      o     = '0;
      lvl   = int'(r.prio);
      found = 1'b0;
      case (r.op)
         swq_pkg::OP_ENQUEUE: begin
            if (mirror_blocked) begin
               o.status = swq_pkg::ST_BLOCKED;
            end else if (lvl >= NLEV) begin
               o.status = swq_pkg::ST_BAD_PRIO;
            end else if (mirror_count[lvl] >= DEPTH) begin
               o.status = swq_pkg::ST_FULL;
            end else begin
               mirror_slot[lvl*DEPTH + mirror_wr[lvl]] = r.handle;
               mirror_wr[lvl] = (mirror_wr[lvl] + 1) % DEPTH;
               mirror_count[lvl]++;
               o.wake = 1'b1;
            end
         end
         swq_pkg::OP_DEQUEUE: begin
            for (int lv = NLEV - 1; lv >= 0; lv--) begin
               if (!found && mirror_count[lv] != 0) begin
                  o.handle = mirror_slot[lv*DEPTH + mirror_rd[lv]];
                  o.level  = swq_pkg::OLEVEL_W'(lv);
                  mirror_rd[lv] = (mirror_rd[lv] + 1) % DEPTH;
                  mirror_count[lv]--;
                  found = 1'b1;
               end
            end
            if (!found) begin
               o.status   = swq_pkg::ST_NOTHING;
               o.empty_ev = mirror_blocked;
            end
         end
         swq_pkg::OP_CLEAR: begin
            for (int lv = 0; lv < NLEV; lv++) begin
               mirror_rd[lv]    = 0;
               mirror_wr[lv]    = 0;
               mirror_count[lv] = 0;
            end
         end
         default: begin
            mirror_blocked = 1'b1;
            o.empty_ev     = (queued_total() == 0);
         end
      endcase
      total       = queued_total();
      o.total     = (total > swq_pkg::TOTAL_MAX) ? swq_pkg::TOTAL_W'(swq_pkg::TOTAL_MAX)
                                                 : swq_pkg::TOTAL_W'(total);
      o.all_empty = (total == 0);
      queue_outcomes.push_back(o);
   endfunction

   function automatic void push_op(input logic [swq_pkg::OP_W-1:0] op, input int prio,
                                   input logic [HW-1:0] h);
      work_req_type r;
      r.op     = op;
      r.prio   = swq_pkg::PRIO_W'(prio);
      r.handle = h;
      ops_to_send.push_back(r);
   endfunction

   function automatic logic [HW-1:0] rand_handle();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return HW'($urandom);
      endcase
   endfunction

   // bursts that fill one level past full, bursts that drain, and mixed traffic;
   // block stays out since it is sticky
   function automatic void add_random_ops(input int n);
      int left;
      int kind;
      int len;
      int lvl;
      int pick;
      left = n;
      while (left > 0) begin
         kind = $urandom_range(9);
         len  = $urandom_range(4, 20);
         if (len > left) len = left;
         lvl  = $urandom_range(NLEV - 1);
         for (int k = 0; k < len; k++) begin
            if (kind < 3) begin
               push_op(swq_pkg::OP_ENQUEUE, lvl, rand_handle());
            end else if (kind < 5) begin
               push_op(swq_pkg::OP_DEQUEUE, $urandom_range(3), rand_handle());
            end else begin
               pick = $urandom_range(99);
               if (pick < 50)
                  push_op(swq_pkg::OP_ENQUEUE, $urandom_range(NLEV - 1), rand_handle());
               else if (pick < 88)
                  push_op(swq_pkg::OP_DEQUEUE, $urandom_range(3), rand_handle());
               else if (pick < 98)
                  push_op(swq_pkg::OP_ENQUEUE, 3, rand_handle());
               else
                  push_op(swq_pkg::OP_CLEAR, $urandom_range(3), rand_handle());
            end
         end
         left -= len;
      end
   endfunction

   task automatic wait_drained();
      while (ops_to_send.size() != 0 || queue_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic void log_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   // request driver: offers ops_to_send[0], pops it on transfer
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            apply_work_op(ops_to_send.pop_front());
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.valid        <= 1'b1;
               req_chan.operation    <= ops_to_send[0].op;
               req_chan.priority_req <= ops_to_send[0].prio;
               req_chan.item_handle  <= ops_to_send[0].handle;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      work_rsp_type seen;
      work_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.status    = rsp_chan.status;
            seen.handle    = rsp_chan.out_handle;
            seen.level     = rsp_chan.out_level;
            seen.total     = rsp_chan.total_length;
            seen.all_empty = rsp_chan.all_empty;
            seen.empty_ev  = rsp_chan.empty_event;
            seen.wake      = rsp_chan.wake_pulse;
            if (queue_outcomes.size() == 0) begin
               log_error($sformatf("unexpected result transfer: status=%0d handle=%h",
                                   seen.status, seen.handle));
            end else begin
               want = queue_outcomes.pop_front();
               if (seen !== want)
                  log_error($sformatf({"mismatch: exp st=%0d h=%h lv=%0d tot=%0d e=%b ev=%b",
                                       " wk=%b / got st=%0d h=%h lv=%0d tot=%0d e=%b ev=%b wk=%b"},
                                      want.status, want.handle, want.level, want.total,
                                      want.all_empty, want.empty_ev, want.wake,
                                      seen.status, seen.handle, seen.level, seen.total,
                                      seen.all_empty, seen.empty_ev, seen.wake));
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, started by a toggle from the sequence
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_toggle != hold_seen) begin
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_toggle;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** strict_priority_work_queue: FAILED **");
         $finish;
      end
   end

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.operation    = swq_pkg::OP_ENQUEUE;
      req_chan.priority_req = '0;
      req_chan.item_handle  = '0;
      rsp_chan.ready        = 1'b0;
      send_idle_pct         = 0;
      recv_stall_pct        = 0;
      hold_toggle           = 1'b0;
      error_count           = 0;
      cycle_count           = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty dequeue, every level, bad level, priority order, clear
      push_op(swq_pkg::OP_DEQUEUE, 0, '0);
      push_op(swq_pkg::OP_ENQUEUE, 0, 16'h0000);
      push_op(swq_pkg::OP_ENQUEUE, 1, 16'hFFFF);
      push_op(swq_pkg::OP_ENQUEUE, 2, 16'hAAAA);
      push_op(swq_pkg::OP_ENQUEUE, 2, 16'h5555);
      push_op(swq_pkg::OP_ENQUEUE, 3, 16'h1234);
      push_op(swq_pkg::OP_ENQUEUE, 0, 16'h8001);
      repeat (6) push_op(swq_pkg::OP_DEQUEUE, 3, 16'hFFFF);
      push_op(swq_pkg::OP_ENQUEUE, 1, 16'h7FFE);
      push_op(swq_pkg::OP_ENQUEUE, 0, 16'h0001);
      push_op(swq_pkg::OP_CLEAR, 1, 16'h0F0F);
      push_op(swq_pkg::OP_DEQUEUE, 2, '0);
      wait_drained();

      // no idling; receiver holds off while the sender keeps offering
      add_random_ops(300);
      hold_toggle <= ~hold_toggle;
      add_random_ops(200);
      wait_drained();

      send_idle_pct  <= 85;
      recv_stall_pct <= 0;
      add_random_ops(480);
      wait_drained();

      send_idle_pct  <= 0;
      recv_stall_pct <= 85;
      add_random_ops(480);
      wait_drained();

      send_idle_pct  <= 27;
      recv_stall_pct <= 27;
      add_random_ops(480);
      wait_drained();

      // blocked behavior last, since the flag only clears on reset
      push_op(swq_pkg::OP_CLEAR, 0, '0);
      push_op(swq_pkg::OP_ENQUEUE, 2, 16'h00FF);
      push_op(swq_pkg::OP_ENQUEUE, 0, 16'hFF00);
      push_op(swq_pkg::OP_BLOCK, 0, '0);
      push_op(swq_pkg::OP_ENQUEUE, 1, 16'h1357);
      push_op(swq_pkg::OP_ENQUEUE, 3, 16'h2468);
      push_op(swq_pkg::OP_BLOCK, 3, 16'hFFFF);
      push_op(swq_pkg::OP_DEQUEUE, 0, '0);
      push_op(swq_pkg::OP_DEQUEUE, 0, '0);
      push_op(swq_pkg::OP_DEQUEUE, 0, '0);
      push_op(swq_pkg::OP_BLOCK, 2, 16'h5A5A);
      push_op(swq_pkg::OP_CLEAR, 0, '0);
      push_op(swq_pkg::OP_ENQUEUE, 0, 16'h0001);
      push_op(swq_pkg::OP_DEQUEUE, 1, '0);
      wait_drained();

      repeat (6) @(posedge clock);
      if (error_count == 0)
         $display("** strict_priority_work_queue: PASSED **");
      else
         $display("** strict_priority_work_queue: FAILED **");
      $finish;
   end

endmodule
